@@ rtl/ajb_pkg.sv @@
// Shared types, codes and defaults for the adaptive jitter buffer.
package ajb_pkg;

   localparam int RING_DEPTH_DEF  = 64;
   localparam int WINDOW_MAX_DEF  = 64;
   localparam int FRAME_MS_DEF    = 20;
   localparam int HANDLE_BITS_DEF = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_DEPTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING_DEPTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTART_DIST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_QUIET_SPACING = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PATIENCE      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_BAND     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPT_ENABLE  = 3'd7;

   localparam logic [6:0]  BASE_DEPTH_RST    = 7'd3;
   localparam logic [6:0]  CEILING_DEPTH_RST = 7'd10;
   localparam logic [15:0] RESTART_DIST_RST  = 16'd256;
   localparam logic [6:0]  WINDOW_LEN_RST    = 7'd32;
   localparam logic [15:0] QUIET_SPACING_RST = 16'd50;
   localparam logic [15:0] PATIENCE_RST      = 16'd250;
   localparam logic [17:0] BIAS_BAND_RST     = 18'd4096;

   localparam logic [2:0] PS_ACCEPTED  = 3'd0;
   localparam logic [2:0] PS_RESET     = 3'd1;
   localparam logic [2:0] PS_LATE      = 3'd2;
   localparam logic [2:0] PS_OVERFLOW  = 3'd3;
   localparam logic [2:0] PS_DUPLICATE = 3'd4;

   localparam logic [1:0] PK_STARVED  = 2'd0;
   localparam logic [1:0] PK_INSERTED = 2'd1;
   localparam logic [1:0] PK_FRAME    = 2'd2;
   localparam logic [1:0] PK_LOST     = 2'd3;

   typedef struct packed {
      logic load;
      logic idx_start;
      logic idx_step;
      logic rd_slot;
      logic push_dec;
      logic obs_start;
      logic mod_step;
      logic win_write;
      logic scan_init;
      logic scan_step;
      logic tgt_init;
      logic tgt_step;
      logic tgt_fin;
      logic push_fin;
      logic pop_a;
      logic pop_b;
      logic play;
   } ajb_cmd_type;

   typedef struct packed {
      logic mode;
      logic adapt;
      logic idx_done;
      logic obs_go;
      logic ptr_ok;
      logic fill_lt2;
      logic scan_done;
      logic tgt_done;
      logic pop_quit;
      logic pb_insert;
      logic pb_skip;
   } ajb_stat_type;

endpackage

@@ rtl/adaptive_jitter_buffer.sv @@
// Adaptive jitter buffer: a push reduces its sequence number to a slot index and reads the
// slot; when jitter tracking is on it then records the arrival in the transit window, with
// one window pointer reduction per step after the window is shortened, and once two transit
// samples are held it scans the window serially through its one-port memory and runs the
// target search, adding FRAME_MS per step until the spread is covered, stopped below
// ceiling_depth. A pop runs the three-step reciprocal sequence to slot index reduction for
// each slot looked up, again for the next slot when a frame is skipped. One request at a
// time is accepted while busy is low. Each result appears for exactly one cycle with
// rsp_valid and must be taken then; the receiver cannot stall. Configuration writes are
// always ready and should be made while idle.
module adaptive_jitter_buffer #(
   parameter int RING_DEPTH  = ajb_pkg::RING_DEPTH_DEF,
   parameter int WINDOW_MAX  = ajb_pkg::WINDOW_MAX_DEF,
   parameter int FRAME_MS    = ajb_pkg::FRAME_MS_DEF,
   parameter int HANDLE_BITS = ajb_pkg::HANDLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_mode,
   input  logic [31:0]                     req_seq_number,
   input  logic [HANDLE_BITS-1:0]          req_frame_handle,
   input  logic [31:0]                     req_arrival_ms,
   input  logic                            req_quiet,
   output logic                            rsp_valid,
   output logic [2:0]                      rsp_push_status,
   output logic [1:0]                      rsp_pop_kind,
   output logic [31:0]                     rsp_play_seq,
   output logic [HANDLE_BITS-1:0]          rsp_play_handle,
   output logic                            rsp_skip_valid,
   output logic [HANDLE_BITS-1:0]          rsp_skip_handle,
   output logic [6:0]                      rsp_target_now,
   output logic [15:0]                     rsp_jitter_spread,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ajb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ajb_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ajb_pkg::*;

   ajb_cmd_type  cmd;
   ajb_stat_type stat;

   assign csr_ready = 1'b1;

   ajb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   ajb_data #(
      .RING_DEPTH  (RING_DEPTH),
      .WINDOW_MAX  (WINDOW_MAX),
      .FRAME_MS    (FRAME_MS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_data (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_mode          (req_mode),
      .req_seq_number    (req_seq_number),
      .req_frame_handle  (req_frame_handle),
      .req_arrival_ms    (req_arrival_ms),
      .req_quiet         (req_quiet),
      .rsp_push_status   (rsp_push_status),
      .rsp_pop_kind      (rsp_pop_kind),
      .rsp_play_seq      (rsp_play_seq),
      .rsp_play_handle   (rsp_play_handle),
      .rsp_skip_valid    (rsp_skip_valid),
      .rsp_skip_handle   (rsp_skip_handle),
      .rsp_target_now    (rsp_target_now),
      .rsp_jitter_spread (rsp_jitter_spread)
   );

`ifndef SYNTHESIS
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request accepted but not busy");
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back to back results");
   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_push_status == PS_ACCEPTED
                     || (rsp_pop_kind == PK_STARVED && !rsp_skip_valid)))
      else $error("push and pop fields mixed");
`endif

endmodule

@@ rtl/ajb_ctrl.sv @@
// Sequencing state machine of the adaptive jitter buffer.
module ajb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   input  ajb_pkg::ajb_stat_type stat,
   output ajb_pkg::ajb_cmd_type  cmd
);
   import ajb_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ISTART = 4'd1;
   localparam logic [3:0] S_IDX    = 4'd2;
   localparam logic [3:0] S_PDEC   = 4'd3;
   localparam logic [3:0] S_OBS    = 4'd4;
   localparam logic [3:0] S_MOD    = 4'd5;
   localparam logic [3:0] S_CHK    = 4'd6;
   localparam logic [3:0] S_SCAN   = 4'd7;
   localparam logic [3:0] S_TGT    = 4'd8;
   localparam logic [3:0] S_PFIN   = 4'd9;
   localparam logic [3:0] S_POPA   = 4'd10;
   localparam logic [3:0] S_POPB   = 4'd11;
   localparam logic [3:0] S_PLAY   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       second_ff, second_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      second_in    = second_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load  = 1'b1;
               second_in = 1'b0;
               state_in  = S_ISTART;
            end
         end
         S_ISTART: begin
            cmd.idx_start = 1'b1;
            state_in      = S_IDX;
         end
         S_IDX: begin
            if (stat.idx_done) begin
               cmd.rd_slot = 1'b1;
               if (!stat.mode) state_in = S_PDEC;
               else if (second_ff) state_in = S_PLAY;
               else state_in = S_POPA;
            end else begin
               cmd.idx_step = 1'b1;
            end
         end
         S_PDEC: begin
            cmd.push_dec = 1'b1;
            state_in     = stat.obs_go ? S_OBS : S_PFIN;
         end
         S_OBS: begin
            cmd.obs_start = 1'b1;
            state_in      = S_MOD;
         end
         S_MOD: begin
            if (stat.ptr_ok) begin
               cmd.win_write = 1'b1;
               state_in      = S_CHK;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         S_CHK: begin
            if (stat.fill_lt2) begin
               state_in = S_PFIN;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               cmd.tgt_init = 1'b1;
               state_in     = S_TGT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_TGT: begin
            if (stat.tgt_done) begin
               cmd.tgt_fin = 1'b1;
               state_in    = S_PFIN;
            end else begin
               cmd.tgt_step = 1'b1;
            end
         end
         S_PFIN: begin
            cmd.push_fin = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_POPA: begin
            cmd.pop_a = 1'b1;
            if (stat.pop_quit) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = stat.adapt ? S_POPB : S_PLAY;
            end
         end
         S_POPB: begin
            cmd.pop_b = 1'b1;
            priority if (stat.pb_insert) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (stat.pb_skip) begin
               second_in = 1'b1;
               state_in  = S_ISTART;
            end else begin
               state_in = S_PLAY;
            end
         end
         S_PLAY: begin
            cmd.play     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/ajb_data.sv @@
// Datapath of the adaptive jitter buffer: ring, transit window, average and registers.
module ajb_data #(
   parameter int RING_DEPTH  = ajb_pkg::RING_DEPTH_DEF,
   parameter int WINDOW_MAX  = ajb_pkg::WINDOW_MAX_DEF,
   parameter int FRAME_MS    = ajb_pkg::FRAME_MS_DEF,
   parameter int HANDLE_BITS = ajb_pkg::HANDLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ajb_pkg::ajb_cmd_type            cmd,
   output ajb_pkg::ajb_stat_type           stat,
   input  logic                            csr_we,
   input  logic [ajb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ajb_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            req_mode,
   input  logic [31:0]                     req_seq_number,
   input  logic [HANDLE_BITS-1:0]          req_frame_handle,
   input  logic [31:0]                     req_arrival_ms,
   input  logic                            req_quiet,
   output logic [2:0]                      rsp_push_status,
   output logic [1:0]                      rsp_pop_kind,
   output logic [31:0]                     rsp_play_seq,
   output logic [HANDLE_BITS-1:0]          rsp_play_handle,
   output logic                            rsp_skip_valid,
   output logic [HANDLE_BITS-1:0]          rsp_skip_handle,
   output logic [6:0]                      rsp_target_now,
   output logic [15:0]                     rsp_jitter_spread
);
   import ajb_pkg::*;

   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FW    = $clog2(RING_DEPTH + 1);
   localparam int PW    = $clog2(WINDOW_MAX);
   localparam int WW    = $clog2(WINDOW_MAX + 1);
   localparam int L_SH  = $clog2(RING_DEPTH);
   // rounded-up reciprocal of the ring depth, exact for every 32-bit sequence number
   localparam longint unsigned REC_FULL =
      ((64'd1 << (32 + L_SH)) + 64'(RING_DEPTH - 1)) / 64'(RING_DEPTH);
   localparam logic [33:0] REC_M = 34'(REC_FULL);
   localparam logic signed [33:0] RING_S = 34'(RING_DEPTH);

   function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
      if (v > 26'sd8388607) return 24'sh7FFFFF;
      if (v < -26'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   function automatic logic [15:0] inc16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   // configuration
   logic [6:0]  base_ff, ceil_ff, wlen_ff;
   logic [15:0] rdist_ff, qsp_ff, pat_ff;
   logic [17:0] band_ff;
   logic        aen_ff;

   // latched request
   logic                   mode_ff, quiet_ff;
   logic [31:0]            seq_ff, arr_ff;
   logic [HANDLE_BITS-1:0] hdl_ff;

   // index unit
   logic [31:0]    op_ff, op_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic [65:0]    prod_ff, prod_in;
   logic [15:0]    mul_half;
   logic [49:0]    mul_p;
   logic [31:0]    quo_c, rem32;

   // slot ring
   logic [RING_DEPTH-1:0]  valid_ff, valid_in;
   logic [31:0]            seq_mem [RING_DEPTH];
   logic [HANDLE_BITS-1:0] hdl_mem [RING_DEPTH];
   logic                   slot_we;
   logic                   rd_valid_ff;
   logic [31:0]            rd_seq_ff;
   logic [HANDLE_BITS-1:0] rd_hdl_ff;

   // stream state
   logic [FW-1:0] frames_ff, frames_in;
   logic          started_ff, started_in, priming_ff, priming_in, played_ff, played_in;
   logic [31:0]   np_ff, np_in, high_ff, high_in, origin_ff, origin_in;
   logic          chk_prime_ff, chk_prime_in;

   // transit window
   logic [31:0]   ring_mem [WINDOW_MAX];
   logic [31:0]   ring_q_ff;
   logic [WW-1:0] fill_ff, fill_in, wsize_ff, wsize_in, sidx_ff, sidx_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic          pend_ff, pend_in;
   logic [31:0]   newest_ff, newest_in;
   logic signed [31:0] lo_ff, lo_in, hi_ff, hi_in, dlt;
   logic [31:0]   spread_ff, spread_in;
   logic [32:0]   spread33;
   logic [32:0]   acc_ff, acc_in;
   logic [6:0]    q_ff, q_in;
   logic [7:0]    need1, need2;
   logic [6:0]    target_ff, target_in;
   logic [15:0]   sprd_ff, sprd_in;

   // average and pacing
   logic signed [23:0] avg_ff, avg_in;
   logic               seeded_ff, seeded_in;
   logic [15:0]        psf_ff, psf_in, biased_ff, biased_in, bnew;
   logic signed [11:0] cur_ff, cur_in, cur_c;
   logic signed [31:0] cur_raw;
   logic signed [25:0] diff26, step26, bias26, band26;
   logic               low_c, high_c, due_c, holds_c;

   // results
   logic [2:0]             pstat_ff, pstat_in;
   logic [1:0]             pkind_ff, pkind_in;
   logic [31:0]            pseq_ff, pseq_in;
   logic [HANDLE_BITS-1:0] phdl_ff, phdl_in, skh_ff, skh_in;
   logic                   skv_ff, skv_in;

   // push decision
   logic [31:0]        ahead_u, hr_u, hg_u;
   logic signed [33:0] ah_s, aha_s, r_s, hr_s;
   logic               adj_c, restart_c, late_c, over_c, dup_c, accept_c;

   always_comb begin
      ahead_u   = seq_ff - np_ff;
      hr_u      = high_ff - seq_ff;
      hg_u      = seq_ff - high_ff;
      ah_s      = {{2{ahead_u[31]}}, ahead_u};
      hr_s      = {{2{hr_u[31]}}, hr_u};
      r_s       = {18'b0, rdist_ff};
      adj_c     = started_ff && priming_ff && !played_ff && ah_s < 0 && ah_s > -r_s
                  && hr_s < RING_S;
      aha_s     = adj_c ? 34'sd0 : ah_s;
      restart_c = !started_ff || aha_s <= -r_s || aha_s >= r_s;
      late_c    = !restart_c && aha_s < 0;
      over_c    = !restart_c && !late_c && aha_s >= RING_S;
      dup_c     = !restart_c && !late_c && !over_c && rd_valid_ff && rd_seq_ff == seq_ff;
      accept_c  = !restart_c && !late_c && !over_c && !dup_c;

      holds_c  = rd_valid_ff && rd_seq_ff == np_ff;
      cur_raw  = $signed(high_ff + 32'd1 - np_ff);
      if (cur_raw > 32'sd2047) cur_c = 12'sd2047;
      else if (cur_raw < -32'sd2048) cur_c = -12'sd2048;
      else cur_c = cur_raw[11:0];
      diff26 = $signed({{2{cur_c[11]}}, cur_c, 12'b0}) - 26'(avg_ff) + 26'sd32;
      step26 = diff26 >>> 6;
      bias26 = 26'(avg_ff) - $signed({7'b0, target_ff, 12'b0});
      band26 = $signed({8'b0, band_ff});
      low_c  = bias26 <= -band26;
      high_c = !low_c && bias26 >= band26 && cur_ff >= 12'sd2;
      bnew   = inc16(biased_ff);
      due_c  = (quiet_ff && psf_ff >= qsp_ff) || bnew >= pat_ff;

      mul_half = (cnt_ff == 6'd3) ? op_ff[15:0] : op_ff[31:16];
      mul_p    = {34'b0, mul_half} * {16'b0, REC_M};
      quo_c    = 32'(prod_ff >> (32 + L_SH));
      rem32    = op_ff - quo_c * 32'(RING_DEPTH);
      dlt      = $signed(ring_q_ff - newest_ff);
      spread33 = {hi_ff[31], hi_ff} - {lo_ff[31], lo_ff};
      need1    = {1'b0, q_ff} + 8'd1;
      need2    = (need1 > {1'b0, ceil_ff}) ? {1'b0, ceil_ff} : need1;
   end

   always_comb begin
      stat.mode      = mode_ff;
      stat.adapt     = aen_ff;
      stat.idx_done  = (cnt_ff == 6'd0);
      stat.obs_go    = aen_ff && (restart_c || late_c || accept_c);
      stat.ptr_ok    = 32'(ptr_ff) < 32'(wsize_ff);
      stat.fill_lt2  = fill_ff < WW'(2);
      stat.scan_done = !pend_ff && sidx_ff >= fill_ff;
      stat.tgt_done  = !(acc_ff < {1'b0, spread_ff} && need1 < {1'b0, ceil_ff});
      stat.pop_quit  = !started_ff || priming_ff || frames_ff == '0;
      stat.pb_insert = low_c && (!holds_c || frames_ff <= FW'(1) || due_c);
      stat.pb_skip   = high_c && (!holds_c || due_c);
   end

   always_comb begin
      op_in = op_ff; rem_in = rem_ff; cnt_in = cnt_ff; prod_in = prod_ff;
      valid_in = valid_ff; slot_we = 1'b0;
      frames_in = frames_ff; started_in = started_ff; priming_in = priming_ff;
      played_in = played_ff; np_in = np_ff; high_in = high_ff; origin_in = origin_ff;
      chk_prime_in = chk_prime_ff;
      fill_in = fill_ff; wsize_in = wsize_ff; sidx_in = sidx_ff; ptr_in = ptr_ff;
      pend_in = pend_ff; newest_in = newest_ff; lo_in = lo_ff; hi_in = hi_ff;
      spread_in = spread_ff; acc_in = acc_ff; q_in = q_ff;
      target_in = target_ff; sprd_in = sprd_ff;
      avg_in = avg_ff; seeded_in = seeded_ff; psf_in = psf_ff; biased_in = biased_ff;
      cur_in = cur_ff;
      pstat_in = pstat_ff; pkind_in = pkind_ff; pseq_in = pseq_ff; phdl_in = phdl_ff;
      skv_in = skv_ff; skh_in = skh_ff;

      if (cmd.load) begin
         pstat_in = PS_ACCEPTED; pkind_in = PK_STARVED; pseq_in = '0;
         phdl_in = '0; skv_in = 1'b0; skh_in = '0;
      end
      if (cmd.idx_start) begin
         op_in   = mode_ff ? np_ff : seq_ff;
         rem_in  = '0;
         prod_in = '0;
         cnt_in  = 6'd3;
      end
      if (cmd.idx_step) begin
         // low half product, high half product, then remainder
         if (cnt_ff == 6'd3) prod_in = {16'b0, mul_p};
         else if (cnt_ff == 6'd2) prod_in = prod_ff + {mul_p, 16'b0};
         else rem_in = IDX_W'(rem32);
         cnt_in = cnt_ff - 6'd1;
      end
      if (cmd.push_dec) begin
         chk_prime_in = restart_c || accept_c;
         if (adj_c) np_in = seq_ff;
         priority if (restart_c) begin
            pstat_in = started_ff ? PS_RESET : PS_ACCEPTED;
            valid_in = '0;
            valid_in[rem_ff] = 1'b1;
            slot_we = 1'b1;
            np_in = seq_ff; high_in = seq_ff; origin_in = seq_ff;
            started_in = 1'b1; priming_in = 1'b1; played_in = 1'b0;
            fill_in = '0; ptr_in = '0; seeded_in = 1'b0; psf_in = '0; biased_in = '0;
            frames_in = FW'(1);
         end else if (late_c) begin
            pstat_in = PS_LATE;
         end else if (over_c) begin
            pstat_in = PS_OVERFLOW;
         end else if (dup_c) begin
            pstat_in = PS_DUPLICATE;
         end else begin
            pstat_in = PS_ACCEPTED;
            if (!rd_valid_ff) frames_in = frames_ff + FW'(1);
            valid_in[rem_ff] = 1'b1;
            slot_we = 1'b1;
            if (!hg_u[31] && hg_u != 32'd0) high_in = seq_ff;
         end
      end
      if (cmd.obs_start) begin
         newest_in = arr_ff - (seq_ff - origin_ff) * 32'(FRAME_MS);
         if (32'(wlen_ff) < 32'd2) wsize_in = WW'(2);
         else if (32'(wlen_ff) > 32'(WINDOW_MAX)) wsize_in = WW'(WINDOW_MAX);
         else wsize_in = WW'(wlen_ff);
      end
      if (cmd.mod_step) ptr_in = PW'(32'(ptr_ff) - 32'(wsize_ff));
      if (cmd.win_write) begin
         ptr_in  = (32'(ptr_ff) + 32'd1 == 32'(wsize_ff)) ? '0 : PW'(32'(ptr_ff) + 32'd1);
         fill_in = (32'(fill_ff) + 32'd1 < 32'(wsize_ff)) ?
                   WW'(32'(fill_ff) + 32'd1) : wsize_ff;
      end
      if (cmd.scan_init) begin
         sidx_in = '0; pend_in = 1'b0; lo_in = '0; hi_in = '0;
      end
      if (cmd.scan_step) begin
         if (pend_ff) begin
            if (dlt < lo_ff) lo_in = dlt;
            if (dlt > hi_ff) hi_in = dlt;
         end
         pend_in = sidx_ff < fill_ff;
         if (sidx_ff < fill_ff) sidx_in = sidx_ff + WW'(1);
      end
      if (cmd.tgt_init) begin
         spread_in = spread33[31:0];
         sprd_in   = (spread33[31:0] > 32'd65535) ? 16'hFFFF : spread33[15:0];
         acc_in    = '0;
         q_in      = '0;
      end
      if (cmd.tgt_step) begin
         acc_in = acc_ff + 33'(FRAME_MS);
         q_in   = q_ff + 7'd1;
      end
      if (cmd.tgt_fin) target_in = (need2 < {1'b0, base_ff}) ? base_ff : need2[6:0];
      if (cmd.push_fin) begin
         if (chk_prime_ff && priming_ff && 32'(frames_ff) >= 32'(target_ff))
            priming_in = 1'b0;
      end
      if (cmd.pop_a) begin
         pseq_in = np_ff;
         if (started_ff && !priming_ff && frames_ff != '0) begin
            if (aen_ff) begin
               cur_in    = cur_c;
               avg_in    = seeded_ff ? sat24(26'(avg_ff) + step26)
                                     : {cur_c, 12'b0};
               seeded_in = 1'b1;
               psf_in    = inc16(psf_ff);
            end
         end else if (started_ff && frames_ff == '0) begin
            priming_in = 1'b1;
            seeded_in  = 1'b0;
         end
      end
      if (cmd.pop_b) begin
         biased_in = (low_c || high_c) ? bnew : 16'd0;
         if (stat.pb_insert) begin
            avg_in = sat24(26'(avg_ff) + 26'sd4096);
            psf_in = '0; biased_in = '0;
            pkind_in = PK_INSERTED;
            pseq_in = np_ff;
         end else if (stat.pb_skip) begin
            if (holds_c) begin
               skv_in = 1'b1;
               skh_in = rd_hdl_ff;
               valid_in[rem_ff] = 1'b0;
               frames_in = frames_ff - FW'(1);
            end
            np_in = np_ff + 32'd1;
            played_in = 1'b1;
            avg_in = sat24(26'(avg_ff) - 26'sd4096);
            psf_in = '0; biased_in = '0;
         end
      end
      if (cmd.play) begin
         pseq_in = np_ff;
         if (holds_c) begin
            pkind_in = PK_FRAME;
            phdl_in = rd_hdl_ff;
            valid_in[rem_ff] = 1'b0;
            frames_in = frames_ff - FW'(1);
         end else begin
            pkind_in = PK_LOST;
         end
         np_in = np_ff + 32'd1;
         played_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         seq_mem[rem_ff] <= seq_ff;
         hdl_mem[rem_ff] <= hdl_ff;
      end
      if (cmd.rd_slot) begin
         rd_seq_ff <= seq_mem[rem_ff];
         rd_hdl_ff <= hdl_mem[rem_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.win_write) ring_mem[ptr_ff] <= newest_ff;
      if (cmd.scan_step && sidx_ff < fill_ff) ring_q_ff <= ring_mem[sidx_ff[PW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode; seq_ff <= req_seq_number; hdl_ff <= req_frame_handle;
         arr_ff <= req_arrival_ms; quiet_ff <= req_quiet;
      end
      if (cmd.rd_slot) rd_valid_ff <= valid_ff[rem_ff];
      op_ff <= op_in; rem_ff <= rem_in; prod_ff <= prod_in;
      newest_in_reg: begin
         newest_ff <= newest_in; wsize_ff <= wsize_in; sidx_ff <= sidx_in;
         lo_ff <= lo_in; hi_ff <= hi_in; spread_ff <= spread_in;
         acc_ff <= acc_in; q_ff <= q_in; cur_ff <= cur_in;
         pstat_ff <= pstat_in; pkind_ff <= pkind_in; pseq_ff <= pseq_in;
         phdl_ff <= phdl_in; skv_ff <= skv_in; skh_ff <= skh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; valid_ff <= '0; frames_ff <= '0;
         started_ff <= 1'b0; priming_ff <= 1'b1; played_ff <= 1'b0;
         np_ff <= '0; high_ff <= '0; origin_ff <= '0; chk_prime_ff <= 1'b0;
         fill_ff <= '0; ptr_ff <= '0; pend_ff <= 1'b0;
         avg_ff <= '0; seeded_ff <= 1'b0; psf_ff <= '0; biased_ff <= '0;
         target_ff <= BASE_DEPTH_RST; sprd_ff <= '0;
         base_ff <= BASE_DEPTH_RST; ceil_ff <= CEILING_DEPTH_RST;
         rdist_ff <= RESTART_DIST_RST; wlen_ff <= WINDOW_LEN_RST;
         qsp_ff <= QUIET_SPACING_RST; pat_ff <= PATIENCE_RST;
         band_ff <= BIAS_BAND_RST; aen_ff <= 1'b1;
      end else begin
         cnt_ff <= cnt_in; valid_ff <= valid_in; frames_ff <= frames_in;
         started_ff <= started_in; priming_ff <= priming_in; played_ff <= played_in;
         np_ff <= np_in; high_ff <= high_in; origin_ff <= origin_in;
         chk_prime_ff <= chk_prime_in;
         fill_ff <= fill_in; ptr_ff <= ptr_in; pend_ff <= pend_in;
         avg_ff <= avg_in; seeded_ff <= seeded_in; psf_ff <= psf_in;
         biased_ff <= biased_in; target_ff <= target_in; sprd_ff <= sprd_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_BASE_DEPTH:    base_ff  <= csr_data[6:0];
               CSR_CEILING_DEPTH: ceil_ff  <= csr_data[6:0];
               CSR_RESTART_DIST:  rdist_ff <= csr_data[15:0];
               CSR_WINDOW_LEN:    wlen_ff  <= csr_data[6:0];
               CSR_QUIET_SPACING: qsp_ff   <= csr_data[15:0];
               CSR_PATIENCE:      pat_ff   <= csr_data[15:0];
               CSR_BIAS_BAND:     band_ff  <= csr_data[17:0];
               CSR_ADAPT_ENABLE:  aen_ff   <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_push_status   = pstat_ff;
   assign rsp_pop_kind      = pkind_ff;
   assign rsp_play_seq      = pseq_ff;
   assign rsp_play_handle   = phdl_ff;
   assign rsp_skip_valid    = skv_ff;
   assign rsp_skip_handle   = skh_ff;
   assign rsp_target_now    = target_ff;
   assign rsp_jitter_spread = sprd_ff;

endmodule
